[hdl/multi_channel_block_ring_buffer_defines.svh]
// Assertion shorthands shared by the checker.
`ifndef MULTI_CHANNEL_BLOCK_RING_BUFFER_DEFINES_SVH
`define MULTI_CHANNEL_BLOCK_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define MCBRB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle during reset.
`define MCBRB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mcbrb_pkg.sv]
package mcbrb_pkg;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [2:0]         chan;
        logic               block_first;
        logic [6:0]         block_len;
        logic signed [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               accepted;
        logic [6:0]         count;
        logic signed [15:0] out_sample;
        logic               last;
    } out_item_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // capture input transaction, start channel-state read
        logic exec;       // execute the captured item
        logic pull_rd;    // read next sample of a pull
        logic pull_emit;  // load pulled sample into output register
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic need_out;   // item may produce a result in its execute cycle
        logic pull_go;    // pull found samples to drain
        logic pull_last;  // no samples left to read
        logic out_free;   // output register can take a result
    } dp_status_t;

endpackage

[hdl/multi_channel_block_ring_buffer.sv]
// Multi-channel block ring buffer: CHANNELS rings of RING_LEN signed 16-bit samples.
// Input channel (s_valid/s_ready/s_data): push transactions carry one sample each;
//   the block's first transaction names the channel and length, and the block is
//   taken whole or refused whole, reported by one status result. A pull
//   transaction drains every committed sample of a channel, last one marked,
//   or gives one empty result.
// Result channel (m_valid/m_ready/m_data): one output register, held under stall.
// Sequencing: each transaction is captured when taken and executed afterwards in
//   the EXEC state, which waits while a result is due and the output register is
//   full; a block's status is loaded into the output register on execution. A pull
//   makes one registered read of the sample memory for each sample before it enters
//   the output register. The next input is taken once the previous transaction's
//   results have all been loaded for delivery.
// Reset (aresetn low, synchronous): all rings empty, no block open. Channel
//   state sits in a small memory guarded by per-channel valid bits, so no
//   clearing pass is needed; the sample memory is never cleared.
// Stall: while m_ready is low the result holds and the block waits before
//   loading the next result, so nothing is lost.
module multi_channel_block_ring_buffer #(
    parameter int CHANNELS = 8,
    parameter int RING_LEN = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mcbrb_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mcbrb_pkg::out_item_t m_data
);
    import mcbrb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequence one transaction at a time
    mcbrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // ring state, sample memory and output register
    mcbrb_dp #(
        .CHANNELS (CHANNELS),
        .RING_LEN (RING_LEN)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

[hdl/mcbrb_ram.sv]
module mcbrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/mcbrb_ctrl.sv]
module mcbrb_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  mcbrb_pkg::dp_status_t  status,
    output mcbrb_pkg::ctrl_cmd_t   cmd
);
    import mcbrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PULL_RD,
        ST_PULL_WR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // take nothing while reset is held
                s_ready  = aresetn;
                cmd.load = s_valid && aresetn;
                if (s_valid && aresetn) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold while a result is due and the output register is full
                if (!status.need_out || status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = status.pull_go ? ST_PULL_RD : ST_IDLE;
                end
            end
            ST_PULL_RD: begin
                cmd.pull_rd = 1'b1;
                state_next  = ST_PULL_WR;
            end
            ST_PULL_WR: begin
                if (status.out_free) begin
                    cmd.pull_emit = 1'b1;
                    state_next    = status.pull_last ? ST_IDLE : ST_PULL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/mcbrb_dp.sv]
module mcbrb_dp #(
    parameter int CHANNELS = 8,
    parameter int RING_LEN = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mcbrb_pkg::in_item_t   s_data,
    input  mcbrb_pkg::ctrl_cmd_t  cmd,
    output mcbrb_pkg::dp_status_t status,
    input  logic                  m_ready,
    output logic                  m_valid,
    output mcbrb_pkg::out_item_t  m_data
);
    import mcbrb_pkg::*;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_DEPTH  = 1 << CH_W;
    localparam int PTR_W     = $clog2(RING_LEN);
    localparam int FILL_W    = $clog2(RING_LEN + 1);
    localparam int ST_W      = 2 * PTR_W + FILL_W;
    localparam int SMP_AW    = CH_W + PTR_W;
    localparam int SMP_DEPTH = 1 << SMP_AW;

    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W:0] v);
        logic [PTR_W:0] d;
        d = v - (PTR_W+1)'(RING_LEN);
        return (int'(v) >= RING_LEN) ? d[PTR_W-1:0] : v[PTR_W-1:0];
    endfunction

    // captured item and open push block
    in_item_t          item_reg;
    logic [2:0]        block_channel_reg;
    logic [6:0]        block_remaining_reg;
    logic              block_accept_reg;
    logic [5:0]        block_offset_reg;

    // channel state memory {rp, wp, fill}
    logic [CH_DEPTH-1:0] st_valid_reg;
    logic                st_vld_reg;
    logic [CH_W-1:0]     st_raddr;
    logic [2:0]          rd_ch_raw;
    logic                st_we;
    logic [ST_W-1:0]     st_wdata;
    logic [ST_W-1:0]     st_rdata;
    logic [ST_W-1:0]     st_word;
    logic [FILL_W-1:0]   st_fill;
    logic [PTR_W-1:0]    st_wp;
    logic [PTR_W-1:0]    st_rp;

    // sample memory
    logic                smp_we;
    logic [SMP_AW-1:0]   smp_waddr;
    logic [SMP_AW-1:0]   smp_raddr;
    logic [15:0]         smp_rdata;

    // pull drain
    logic [FILL_W-1:0]   pull_left_reg;
    logic [FILL_W-1:0]   pull_n_reg;
    logic [PTR_W-1:0]    rd_pos_reg;

    // output register
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    out_item_t           out_next;
    logic                out_load;

    // decode
    logic              is_pull;
    logic              is_first;
    logic              is_cont;
    logic [2:0]        ch_raw;
    logic              ch_ok;
    logic [CH_W-1:0]   ch_idx;
    logic              len_nz;
    logic              len_ok;
    logic              smp_act;
    logic              acc;
    logic [5:0]        off;
    logic [6:0]        rem;
    logic [6:0]        rem_dec;
    logic [PTR_W-1:0]  pos;
    logic [PTR_W:0]    off_len;
    logic [PTR_W:0]    end_sum;
    logic [FILL_W-1:0] new_fill;
    logic              commit;
    logic              pull_go;

    // Continuation samples follow the open block's channel.
    assign rd_ch_raw = (s_data.cmd == CMD_PUSH && !s_data.block_first)
                       ? block_channel_reg : s_data.chan;
    assign st_raddr  = CH_W'(rd_ch_raw);

    assign is_pull  = (item_reg.cmd == CMD_PULL);
    assign is_first = !is_pull && item_reg.block_first;
    assign is_cont  = !is_pull && !item_reg.block_first && (block_remaining_reg != 7'd0);
    assign ch_raw   = is_cont ? block_channel_reg : item_reg.chan;
    assign ch_ok    = int'(ch_raw) < CHANNELS;
    assign ch_idx   = CH_W'(ch_raw);

    assign st_word  = st_vld_reg ? st_rdata : '0;
    assign st_fill  = st_word[FILL_W-1:0];
    assign st_wp    = st_word[FILL_W +: PTR_W];
    assign st_rp    = st_word[FILL_W+PTR_W +: PTR_W];

    assign len_nz   = (item_reg.block_len != 7'd0);
    assign len_ok   = ch_ok && len_nz && (int'(item_reg.block_len) <= RING_LEN)
                      && (int'(item_reg.block_len) + int'(st_fill) <= RING_LEN);

    assign smp_act  = (is_first && len_nz) || is_cont;
    assign acc      = is_first ? len_ok : block_accept_reg;
    assign off      = is_first ? 6'd0 : block_offset_reg;
    assign rem      = is_first ? item_reg.block_len : block_remaining_reg;
    assign rem_dec  = rem - 7'd1;

    assign pos      = wrap_ptr({1'b0, st_wp} + {1'b0, PTR_W'(off)});
    assign off_len  = (PTR_W+1)'(off) + (PTR_W+1)'(1);
    assign end_sum  = {1'b0, st_wp} + off_len;
    assign new_fill = st_fill + FILL_W'(off_len);

    assign commit   = cmd.exec && smp_act && acc && (rem_dec == 7'd0);
    assign pull_go  = is_pull && ch_ok && (st_fill != '0);

    assign st_we    = commit || (cmd.exec && pull_go);
    assign st_wdata = pull_go
                      ? {wrap_ptr({1'b0, st_rp} + (PTR_W+1)'(st_fill)), st_wp, FILL_W'(0)}
                      : {st_rp, wrap_ptr(end_sum), new_fill};

    assign smp_we    = cmd.exec && smp_act && acc;
    assign smp_waddr = {ch_idx, pos};
    assign smp_raddr = {ch_idx, rd_pos_reg};

    mcbrb_ram #(
        .WIDTH (ST_W),
        .DEPTH (CH_DEPTH)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (ch_idx),
        .wdata (st_wdata),
        .re    (cmd.load),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mcbrb_ram #(
        .WIDTH (16),
        .DEPTH (SMP_DEPTH)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (item_reg.sample),
        .re    (cmd.pull_rd),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
    end

    // Channel-state entries read as zero until first written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= '0;
            st_vld_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                st_vld_reg <= st_valid_reg[st_raddr];
            end
            if (st_we) begin
                st_valid_reg[ch_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_channel_reg   <= '0;
            block_remaining_reg <= '0;
            block_accept_reg    <= 1'b0;
            block_offset_reg    <= '0;
        end else if (cmd.exec) begin
            if (is_first) begin
                block_channel_reg <= item_reg.chan;
            end
            if (is_first && !len_nz) begin
                block_remaining_reg <= '0;
                block_accept_reg    <= 1'b0;
                block_offset_reg    <= '0;
            end else if (smp_act) begin
                block_remaining_reg <= rem_dec;
                if (rem_dec == 7'd0) begin
                    block_accept_reg <= 1'b0;
                    block_offset_reg <= '0;
                end else begin
                    block_accept_reg <= acc;
                    block_offset_reg <= off + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pull_left_reg <= '0;
            pull_n_reg    <= '0;
            rd_pos_reg    <= '0;
        end else if (cmd.exec && pull_go) begin
            pull_left_reg <= st_fill;
            pull_n_reg    <= st_fill;
            rd_pos_reg    <= st_rp;
        end else if (cmd.pull_rd) begin
            pull_left_reg <= pull_left_reg - FILL_W'(1);
            rd_pos_reg    <= wrap_ptr({1'b0, rd_pos_reg} + (PTR_W+1)'(1));
        end
    end

    assign out_load = cmd.pull_emit || (cmd.exec && (is_first || (is_pull && !pull_go)));

    always_comb begin
        out_next = '0;
        priority if (cmd.pull_emit) begin
            out_next.kind       = KIND_SAMPLE;
            out_next.count      = 7'(pull_n_reg);
            out_next.out_sample = smp_rdata;
            out_next.last       = (pull_left_reg == '0);
        end else if (is_first) begin
            out_next.kind     = KIND_STATUS;
            out_next.accepted = len_ok;
            out_next.count    = len_ok ? item_reg.block_len : 7'd0;
            out_next.last     = 1'b1;
        end else begin
            out_next.kind = KIND_EMPTY;
            out_next.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.need_out  = is_pull || is_first;
    assign status.pull_go   = pull_go;
    assign status.pull_last = (pull_left_reg == '0);
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

[hdl/mcbrb_checker.sv]
`include "multi_channel_block_ring_buffer_defines.svh"

module mcbrb_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input mcbrb_pkg::out_item_t m_data
);
    import mcbrb_pkg::*;

    // A stalled result holds.
    `MCBRB_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_data),
        "result changed under stall")

    // One transaction in flight: input closes after each acceptance.
    `MCBRB_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn,
        s_valid && s_ready, !s_ready,
        "input taken back to back")

    // Status and empty results stand alone and carry no sample.
    `MCBRB_ASSERT_NOW(a_single_result, aclk, aresetn,
        m_valid && m_data.kind != KIND_SAMPLE,
        m_data.last && m_data.out_sample == 16'sd0,
        "status or empty result malformed")

    // Refusals and empty pulls report zero count; pulled samples a nonzero one.
    `MCBRB_ASSERT_NOW(a_count, aclk, aresetn, m_valid,
        (m_data.kind == KIND_SAMPLE) ? (m_data.count != 7'd0 && !m_data.accepted)
                                     : (m_data.accepted || m_data.count == 7'd0),
        "result count inconsistent")

endmodule

bind multi_channel_block_ring_buffer mcbrb_checker u_mcbrb_checker (.*);
